FILE: rtl/gffc_pkg.sv
package gffc_pkg;

   localparam int ROW_W      = 64;
   localparam int ID_W       = 6;
   localparam int COLOR_W    = 6;
   localparam int CNT_W      = 7;
   localparam int NUM_COLORS = 64;
   localparam int JOB_DEPTH  = 2;
   localparam int JOB_PTR_W  = 1;
   localparam int JOB_CNT_W  = 2;

   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  addr;
      logic [ROW_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic job_pending;
      logic coloring;
   } hold_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MASK,
      BACK_PICK
   } back_state_type;

endpackage

FILE: rtl/gffc_front.sv
module gffc_front #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gffc_pkg::ROW_W-1:0]    req_adj_row,
   input  logic                          req_row_last,
   input  gffc_pkg::hold_type            hold,
   output gffc_pkg::wr_type              wr,
   output logic                          job_push,
   output logic [gffc_pkg::CNT_W-1:0]    job_count
);

   localparam int CNTP_W = $clog2(MAX_VERTICES + 1);

   logic [CNTP_W-1:0] count_ff;
   logic [CNTP_W-1:0] count_in;
   logic [CNTP_W-1:0] count_next;
   logic              accept;
   logic              room;

   assign req_stall  = hold.job_pending | hold.coloring;
   assign accept     = req_valid & ~req_stall;
   assign room       = count_ff < CNTP_W'(MAX_VERTICES);
   assign count_next = room ? count_ff + 1'b1 : count_ff;

   always_comb begin
      wr.valid  = accept & room;
      wr.addr   = gffc_pkg::ID_W'(count_ff);
      wr.data   = req_adj_row;
      job_push  = accept & req_row_last;
      job_count = gffc_pkg::CNT_W'(count_next);
      count_in  = count_ff;
      if (accept) begin
         count_in = req_row_last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/gffc_job_fifo.sv
module gffc_job_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [gffc_pkg::CNT_W-1:0] push_count,
   input  logic                       pop,
   output logic                       not_empty,
   output logic [gffc_pkg::CNT_W-1:0] head_count
);

   logic [gffc_pkg::CNT_W-1:0]     slot_ff [gffc_pkg::JOB_DEPTH];
   logic [gffc_pkg::JOB_PTR_W-1:0] wr_ptr_ff;
   logic [gffc_pkg::JOB_PTR_W-1:0] rd_ptr_ff;
   logic [gffc_pkg::JOB_CNT_W-1:0] fill_ff;
   logic                           do_push;
   logic                           do_pop;

   assign not_empty  = fill_ff != '0;
   assign head_count = slot_ff[rd_ptr_ff];
   assign do_push    = push & (fill_ff != gffc_pkg::JOB_CNT_W'(gffc_pkg::JOB_DEPTH));
   assign do_pop     = pop & not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/gffc_back.sv
module gffc_back #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gffc_pkg::wr_type              wr,
   input  logic                          job_valid,
   input  logic [gffc_pkg::CNT_W-1:0]    job_count,
   output logic                          job_pop,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gffc_pkg::ID_W-1:0]     rsp_vertex_id,
   output logic [gffc_pkg::COLOR_W-1:0]  rsp_vertex_color,
   output logic                          rsp_color_last
);

   localparam int IDX_W  = $clog2(MAX_VERTICES);
   localparam int CNTP_W = $clog2(MAX_VERTICES + 1);

   logic [gffc_pkg::ROW_W-1:0]      adj_mem [MAX_VERTICES];
   logic [gffc_pkg::ROW_W-1:0]      rd_data_ff;
   logic [gffc_pkg::COLOR_W-1:0]    color_ff [MAX_VERTICES];
   logic [gffc_pkg::NUM_COLORS-1:0] used_ff;
   logic [gffc_pkg::NUM_COLORS-1:0] used_in;
   logic [gffc_pkg::NUM_COLORS-1:0] lane_used;
   logic [IDX_W-1:0]                u_ff;
   logic [IDX_W-1:0]                u_in;
   logic [CNTP_W-1:0]               n_ff;
   logic [CNTP_W-1:0]               n_in;
   gffc_pkg::back_state_type        state_ff;
   gffc_pkg::back_state_type        state_in;
   logic                            rd_en;
   logic [IDX_W-1:0]                rd_addr;
   logic                            load;
   logic                            can_load;
   logic                            last_vertex;
   logic [gffc_pkg::COLOR_W-1:0]    pick_color;
   logic                            rsp_valid_ff;
   logic [gffc_pkg::ID_W-1:0]       rsp_vertex_id_ff;
   logic [gffc_pkg::COLOR_W-1:0]    rsp_vertex_color_ff;
   logic                            rsp_color_last_ff;

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         adj_mem[wr.addr[IDX_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= adj_mem[rd_addr];
      end
   end

   always_comb begin
      lane_used = '0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
         if (rd_data_ff[j] && (IDX_W'(j) < u_ff)) begin
            lane_used[color_ff[j]] = 1'b1;
         end
      end
   end

   always_comb begin
      pick_color = gffc_pkg::COLOR_W'(gffc_pkg::NUM_COLORS - 1);
      for (int c = gffc_pkg::NUM_COLORS - 1; c >= 0; c--) begin
         if (!used_ff[c]) begin
            pick_color = gffc_pkg::COLOR_W'(c);
         end
      end
   end

   assign last_vertex = (CNTP_W'(u_ff) + CNTP_W'(1)) == n_ff;
   assign can_load    = ~rsp_valid_ff | ~rsp_stall;
   assign busy        = state_ff != gffc_pkg::BACK_IDLE;

   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      n_in     = n_ff;
      used_in  = used_ff;
      rd_en    = 1'b0;
      rd_addr  = u_ff;
      job_pop  = 1'b0;
      load     = 1'b0;
      case (state_ff)
         gffc_pkg::BACK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               n_in     = job_count[CNTP_W-1:0];
               u_in     = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = gffc_pkg::BACK_MASK;
            end
         end
         gffc_pkg::BACK_MASK: begin
            used_in = lane_used;
            if (!last_vertex) begin
               rd_en   = 1'b1;
               rd_addr = u_ff + 1'b1;
            end
            state_in = gffc_pkg::BACK_PICK;
         end
         gffc_pkg::BACK_PICK: begin
            if (can_load) begin
               load = 1'b1;
               if (last_vertex) begin
                  state_in = gffc_pkg::BACK_IDLE;
               end else begin
                  u_in     = u_ff + 1'b1;
                  state_in = gffc_pkg::BACK_MASK;
               end
            end
         end
         default: begin
            state_in = gffc_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gffc_pkg::BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      n_ff    <= n_in;
      used_ff <= used_in;
      if (load) begin
         color_ff[u_ff]      <= pick_color;
         rsp_vertex_id_ff    <= gffc_pkg::ID_W'(u_ff);
         rsp_vertex_color_ff <= pick_color;
         rsp_color_last_ff   <= last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_id    = rsp_vertex_id_ff;
   assign rsp_vertex_color = rsp_vertex_color_ff;
   assign rsp_color_last   = rsp_color_last_ff;

endmodule

FILE: rtl/greedy_first_fit_coloring_core.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    adj_row[63:0], row_last
// rsp_      out        rsp_valid/stall    vertex_id[5:0], vertex_color[5:0], color_last
//
// Rows load at one transaction per cycle into the row memory while req_stall is low.
// After the last row, coloring starts by reading row 0, then per vertex does a registered
// memory read, then a color pick; req_stall stays high until all vertices are picked.
// Synchronous reset clears the row count, job queue, sequencer and output valid.
// rsp_stall holds the output register and pauses the color pick.
module greedy_first_fit_coloring_core #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gffc_pkg::ROW_W-1:0]    req_adj_row,
   input  logic                          req_row_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gffc_pkg::ID_W-1:0]     rsp_vertex_id,
   output logic [gffc_pkg::COLOR_W-1:0]  rsp_vertex_color,
   output logic                          rsp_color_last
);

   gffc_pkg::wr_type           wr;
   gffc_pkg::hold_type         hold;
   logic                       job_push;
   logic [gffc_pkg::CNT_W-1:0] job_count;
   logic                       job_pop;
   logic                       job_valid;
   logic [gffc_pkg::CNT_W-1:0] head_count;
   logic                       busy;

   assign hold.job_pending = job_valid;
   assign hold.coloring    = busy;

   gffc_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_adj_row  (req_adj_row),
      .req_row_last (req_row_last),
      .hold         (hold),
      .wr           (wr),
      .job_push     (job_push),
      .job_count    (job_count)
   );

   gffc_job_fifo u_job_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_count (job_count),
      .pop        (job_pop),
      .not_empty  (job_valid),
      .head_count (head_count)
   );

   gffc_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .job_valid        (job_valid),
      .job_count        (head_count),
      .job_pop          (job_pop),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_id    (rsp_vertex_id),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_color_last   (rsp_color_last)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_V       = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ROWS  = 88;

   typedef enum int {
      ROWS_RANDOM,
      ROWS_SPARSE,
      ROWS_DENSE,
      ROWS_FULL
   } row_mix_type;

   class coloring_scoreboard;
      typedef struct {
         logic [gffc_pkg::ID_W-1:0]    id;
         logic [gffc_pkg::COLOR_W-1:0] color;
         logic                         last;
      } vertex_color_type;

      logic [gffc_pkg::ROW_W-1:0]   adj_rows [MAX_V];
      logic [gffc_pkg::COLOR_W-1:0] colors [MAX_V];
      int                           rows_held = 0;
      int                           errors = 0;
      int                           checked = 0;
      vertex_color_type             expected_colors[$];

      function int pending();
         return expected_colors.size();
      endfunction

      function void note_row(logic [gffc_pkg::ROW_W-1:0] row, logic last);
         logic [gffc_pkg::NUM_COLORS-1:0] taken;
         int                              c;
         vertex_color_type                v;
         if (rows_held < MAX_V) begin
            adj_rows[rows_held] = row;
            rows_held++;
         end
         if (!last)
            return;
         for (int u = 0; u < rows_held; u++) begin
            taken = '0;
            for (int j = 0; j < u; j++)
               if (adj_rows[u][j])
                  taken[colors[j]] = 1'b1;
            c = 0;
            while (c < gffc_pkg::NUM_COLORS - 1 && taken[c])
               c++;
            colors[u] = c[gffc_pkg::COLOR_W-1:0];
            v.id    = u[gffc_pkg::ID_W-1:0];
            v.color = c[gffc_pkg::COLOR_W-1:0];
            v.last  = (u == rows_held - 1);
            expected_colors.insert(expected_colors.size(), v);
         end
         rows_held = 0;
      endfunction

      function void check_result(logic [gffc_pkg::ID_W-1:0] id,
                                 logic [gffc_pkg::COLOR_W-1:0] color,
                                 logic last);
         vertex_color_type want;
         if (expected_colors.size() == 0) begin
            $display("%0t: unexpected transaction: vertex %0d color %0d last %0b",
                     $time, id, color, last);
            errors++;
            return;
         end
         want = expected_colors.pop_front();
         checked++;
         if (want.id !== id) begin
            $display("%0t: vertex_id expected %0d, got %0d", $time, want.id, id);
            errors++;
         end
         if (want.color !== color) begin
            $display("%0t: vertex_color of vertex %0d expected %0d, got %0d",
                     $time, want.id, want.color, color);
            errors++;
         end
         if (want.last !== last) begin
            $display("%0t: color_last of vertex %0d expected %0b, got %0b",
                     $time, want.id, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [gffc_pkg::ROW_W-1:0]   req_adj_row;
   logic                         req_row_last;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [gffc_pkg::ID_W-1:0]    rsp_vertex_id;
   logic [gffc_pkg::COLOR_W-1:0] rsp_vertex_color;
   logic                         rsp_color_last;

   coloring_scoreboard sb = new;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rows_sent = 0;
   int graphs_sent = 0;

   greedy_first_fit_coloring_core #(
      .MAX_VERTICES(MAX_V)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adj_row      (req_adj_row),
      .req_row_last     (req_row_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_id    (rsp_vertex_id),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_color_last   (rsp_color_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_vertex_id, rsp_vertex_color, rsp_color_last);
   end

   function automatic logic [gffc_pkg::ROW_W-1:0] make_row(row_mix_type mix);
      logic [gffc_pkg::ROW_W-1:0] a;
      logic [gffc_pkg::ROW_W-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case (mix)
         ROWS_SPARSE: return a & b & {$urandom, $urandom};
         ROWS_DENSE:  return a | b;
         ROWS_FULL:   return '1;
         default:     return a;
      endcase
   endfunction

   task automatic send_row(input logic [gffc_pkg::ROW_W-1:0] row, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_adj_row  <= row;
      req_row_last <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_row(row, last);
      rows_sent++;
   endtask

   task automatic send_graph(input int n, input row_mix_type mix);
      for (int u = 0; u < n; u++)
         send_row(make_row(mix), u == n - 1);
      graphs_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   initial begin
      int          phase_start;
      int          size;
      row_mix_type mix;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_adj_row  <= '0;
      req_row_last <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single vertex, every bit set
      send_row('1, 1'b1);
      // edge to vertex 0
      send_row('0, 1'b0);
      send_row('1, 1'b1);
      // diagonal and upper bits only: no lower neighbor
      send_row('0, 1'b0);
      send_row(~64'h1, 1'b1);
      // triangle
      send_row('0, 1'b0);
      send_row(64'h1, 1'b0);
      send_row(64'h3, 1'b1);
      // path: alternating colors
      send_row('0, 1'b0);
      for (int u = 1; u < 5; u++)
         send_row(64'h1 << (u - 1), u == 4);
      // star on vertex 0 with diagonal bits set
      send_row(64'h1, 1'b0);
      for (int u = 1; u < 4; u++)
         send_row(64'h1 | (64'h1 << u), u == 3);
      // first fit reuses a freed lower color
      send_row('0, 1'b0);
      send_row(64'h1, 1'b0);
      send_row('0, 1'b0);
      send_row(64'h6, 1'b0);
      send_row(64'h9, 1'b1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 57;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 57;
            end
            default: begin
               send_idle_pct = 9;
               stall_pct     = 9;
            end
         endcase
         phase_start = rows_sent;
         if (phase == 0) begin
            // hold the receiver while rows of the next graph keep coming
            hold_req <= hold_req + 1;
            send_graph(12, ROWS_DENSE);
            send_graph(6, ROWS_RANDOM);
            drain();
            send_graph(MAX_V, ROWS_FULL);
         end
         if (phase == 2)
            send_graph(MAX_V + 3, ROWS_DENSE);
         while (rows_sent - phase_start < PHASE_ROWS) begin
            size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            mix  = row_mix_type'($urandom_range(0, 3));
            send_graph(size, mix);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d graphs in %0d rows; checked %0d colored vertices, %0d mismatches",
               graphs_sent, rows_sent, sb.checked, sb.errors);
      $display("Included a 64-vertex clique, a row-store overflow and a long receiver hold-off");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
